// ===== sv/lrsgd_pkg.sv =====
// Shared types, constants and saturation helpers for the linear regression SGD trainer.
package lrsgd_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int COUNT_W   = 16;
    localparam int RATE_W    = 16;
    localparam int SUM_W     = 48;
    localparam int LIMIT_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STATUS_W  = 3;
    localparam int OP_W      = 2;
    localparam int MUL_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int WIDE_W    = PROD_W - FRAC_BITS;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_TRAIN   = 2'd0,
        OP_PREDICT = 2'd1,
        OP_EPOCH   = 2'd2,
        OP_ALT_PRED = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_CONVERGED = 3'd1,
        STS_LIMIT     = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_IGNORED   = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE   = 3'd0,
        CFG_INIT_W = 3'd1,
        CFG_INIT_B = 3'd2,
        CFG_LIMIT  = 3'd3,
        CFG_THRESH = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_WX = 2'd0,
        MUL_ER = 2'd1,
        MUL_GX = 2'd2,
        MUL_TN = 2'd3
    } t_mul_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_PRED,
        S_PRED,
        S_ERR,
        S_MUL_GRAD,
        S_GRAD,
        S_MUL_STEP,
        S_WUPD,
        S_MUL_THR,
        S_EPOCH,
        S_WRITE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     pred;
        logic     err;
        logic     grad;
        logic     wupd;
        logic     epoch;
        logic     write_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic train;
        logic finished;
        logic x_zero;
    } t_sts;

    // Clamp a shifted product to the data range
    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-DATA_W:0] top;
        top = v[WIDE_W-1:DATA_W-1];
        if (top == '0 || top == '1) begin
            return v[DATA_W-1:0];
        end
        return v[WIDE_W-1] ? DATA_MIN : DATA_MAX;
    endfunction

    // Clamp a one-bit-grown sum to the data range
    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W:0] v);
        if (v[DATA_W] == v[DATA_W-1]) begin
            return v[DATA_W-1:0];
        end
        return v[DATA_W] ? DATA_MIN : DATA_MAX;
    endfunction

endpackage

// ===== sv/linear_regression_sgd_trainer_unit.sv =====
// Top level of the linear regression SGD trainer: sequencer plus datapath.
//
//  channel  direction  handshake                    payload
//  in       sink       i_in_valid / o_in_ready      i_opcode, i_x_value, i_y_reference
//  out      source     o_out_valid / i_out_ready    o_prediction, o_sample_error,
//                                                   o_weight_now, o_bias_now,
//                                                   o_status, o_epochs_done
//  cfg      sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Steps: predict w*x, prediction, write; train adds error, e*rate, bias, g*x and
// weight before write (only error if x is zero, none once finished); end of epoch
// thresh*samples, check, write. Products share one registered 33x33 multiplier.
// Reset is synchronous; it restores config defaults and training state, no sweep.
// A result waits in the output register; the next word is taken and computed,
// then holds in its write step until the output register frees.
module linear_regression_sgd_trainer_unit
    import lrsgd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [DATA_W-1:0] i_x_value,
    input  logic signed [DATA_W-1:0] i_y_reference,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_prediction,
    output logic signed [DATA_W-1:0] o_sample_error,
    output logic signed [DATA_W-1:0] o_weight_now,
    output logic signed [DATA_W-1:0] o_bias_now,
    output logic [STATUS_W-1:0]      o_status,
    output logic [COUNT_W-1:0]       o_epochs_done,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Config writes are always accepted and registered
    assign o_cfg_ready = 1'b1;

    lrsgd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lrsgd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_x_value      (i_x_value),
        .i_y_reference  (i_y_reference),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_prediction   (o_prediction),
        .o_sample_error (o_sample_error),
        .o_weight_now   (o_weight_now),
        .o_bias_now     (o_bias_now),
        .o_status       (o_status),
        .o_epochs_done  (o_epochs_done)
    );

endmodule

// ===== sv/lrsgd_ctrl.sv =====
// Sequencer for the trainer: walks each word through the shared multiplier steps.
module lrsgd_ctrl
    import lrsgd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [OP_W-1:0] i_opcode,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  t_sts            i_sts,
    output t_cmd            o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Advance state and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (t_op'(i_opcode) == OP_EPOCH) ? S_MUL_THR : S_MUL_PRED;
                end
            end
            S_MUL_PRED: n_state = S_PRED;
            S_PRED:     n_state = (i_sts.train && !i_sts.finished) ? S_ERR : S_WRITE;
            S_ERR:      n_state = i_sts.x_zero ? S_WRITE : S_MUL_GRAD;
            S_MUL_GRAD: n_state = S_GRAD;
            S_GRAD:     n_state = S_MUL_STEP;
            S_MUL_STEP: n_state = S_WUPD;
            S_WUPD:     n_state = S_WRITE;
            S_MUL_THR:  n_state = S_EPOCH;
            S_EPOCH:    n_state = S_WRITE;
            S_WRITE:    n_state = out_free ? S_IDLE : S_WRITE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Commands and output flag
    always_comb begin
        o_cmd       = '0;
        o_cmd.mul_sel = MUL_WX;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE:     o_cmd.accept = i_in_valid;
            S_MUL_PRED: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_WX;
            end
            S_PRED:     o_cmd.pred = 1'b1;
            S_ERR:      o_cmd.err = 1'b1;
            S_MUL_GRAD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ER;
            end
            S_GRAD:     o_cmd.grad = 1'b1;
            S_MUL_STEP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_GX;
            end
            S_WUPD:     o_cmd.wupd = 1'b1;
            S_MUL_THR:  begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_TN;
            end
            S_EPOCH:    o_cmd.epoch = 1'b1;
            S_WRITE: begin
                if (out_free) begin
                    o_cmd.write_out = 1'b1;
                    n_out_valid     = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/lrsgd_dp.sv =====
// Datapath: model state, config registers, shared multiplier and result register.
module lrsgd_dp
    import lrsgd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [OP_W-1:0]        i_opcode,
    input  logic signed [DATA_W-1:0] i_x_value,
    input  logic signed [DATA_W-1:0] i_y_reference,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    output logic signed [DATA_W-1:0] o_prediction,
    output logic signed [DATA_W-1:0] o_sample_error,
    output logic signed [DATA_W-1:0] o_weight_now,
    output logic signed [DATA_W-1:0] o_bias_now,
    output logic [STATUS_W-1:0]    o_status,
    output logic [COUNT_W-1:0]     o_epochs_done
);

    // Configuration registers
    logic [RATE_W-1:0]         r_rate;
    logic signed [DATA_W-1:0]  r_init_w;
    logic signed [DATA_W-1:0]  r_init_b;
    logic [LIMIT_W-1:0]        r_limit;
    logic [CFG_DATA_W-1:0]     r_thresh;

    // Training state
    logic signed [DATA_W-1:0]  r_w, r_b;
    logic [SUM_W-1:0]          r_esum;
    logic [COUNT_W-1:0]        r_samples, r_count;
    logic                      r_finished, r_fresh;

    // Working registers
    t_op                       r_op;
    logic signed [DATA_W-1:0]  r_x, r_y, r_pred, r_err, r_g;
    logic signed [PROD_W-1:0]  r_prod;
    t_status                   r_status;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [DATA_W-1:0]  prod_q, g_now, pred_now, err_now;
    logic [DATA_W:0]           err_mag;
    logic [SUM_W:0]            esum_add;
    logic [COUNT_W-1:0]        count_inc, samples_inc;
    logic                      load_start, conv;

    assign o_sts.train    = (r_op == OP_TRAIN);
    assign o_sts.finished = r_finished;
    assign o_sts.x_zero   = (r_x == '0);

    // Select multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_WX: begin
                mul_a = {r_w[DATA_W-1], r_w};
                mul_b = {r_x[DATA_W-1], r_x};
            end
            MUL_ER: begin
                mul_a = {r_err[DATA_W-1], r_err};
                mul_b = {{(MUL_W-RATE_W){1'b0}}, r_rate};
            end
            MUL_GX: begin
                mul_a = {r_g[DATA_W-1], r_g};
                mul_b = {r_x[DATA_W-1], r_x};
            end
            default: begin
                mul_a = {{(MUL_W-CFG_DATA_W){1'b0}}, r_thresh};
                mul_b = {{(MUL_W-COUNT_W){1'b0}}, r_samples};
            end
        endcase
    end

    // Floor-shift products and form the arithmetic of each step
    always_comb begin
        prod_q   = sat_wide(r_prod[PROD_W-1:FRAC_BITS]);
        // |e*rate| stays below 2^(DATA_W-1+RATE_W), so the slice is exact
        g_now    = r_prod[RATE_W +: DATA_W];
        pred_now = sat_sum({prod_q[DATA_W-1], prod_q} + {r_b[DATA_W-1], r_b});
        err_now  = sat_sum({r_y[DATA_W-1], r_y} - {r_pred[DATA_W-1], r_pred});
        err_mag  = r_err[DATA_W-1] ? (DATA_W+1)'(-{r_err[DATA_W-1], r_err})
                                   : {1'b0, r_err};
        esum_add = {1'b0, r_esum} + {{(SUM_W-DATA_W){1'b0}}, err_mag};
        count_inc   = (r_count == '1) ? r_count : r_count + 1'b1;
        samples_inc = (r_samples == '1) ? r_samples : r_samples + 1'b1;
        conv     = r_esum < r_prod[SUM_W-1:0];
        load_start = (t_op'(i_opcode) == OP_TRAIN) && r_fresh && !r_finished;
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= RATE_W'(656);
            r_init_w <= DATA_W'(32768);
            r_init_b <= DATA_W'(32768);
            r_limit  <= LIMIT_W'(1000);
            r_thresh <= CFG_DATA_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RATE:   r_rate   <= i_cfg_data[RATE_W-1:0];
                CFG_INIT_W: r_init_w <= i_cfg_data[DATA_W-1:0];
                CFG_INIT_B: r_init_b <= i_cfg_data[DATA_W-1:0];
                CFG_LIMIT:  r_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_THRESH: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Training state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= '0;
            r_b        <= '0;
            r_esum     <= '0;
            r_samples  <= '0;
            r_count    <= '0;
            r_finished <= 1'b0;
            r_fresh    <= 1'b1;
        end else begin
            if (i_cmd.accept && load_start) begin
                r_w     <= r_init_w;
                r_b     <= r_init_b;
                r_fresh <= 1'b0;
            end
            if (i_cmd.err) begin
                r_samples <= samples_inc;
                // zero x: bias takes the reference directly
                if (r_x == '0) begin
                    r_b <= r_y;
                end
            end
            if (i_cmd.grad) begin
                r_b <= sat_sum({r_b[DATA_W-1], r_b} + {g_now[DATA_W-1], g_now});
            end
            if (i_cmd.wupd) begin
                r_w    <= sat_sum({r_w[DATA_W-1], r_w} + {prod_q[DATA_W-1], prod_q});
                r_esum <= esum_add[SUM_W] ? {SUM_W{1'b1}} : esum_add[SUM_W-1:0];
            end
            if (i_cmd.epoch && !r_finished && r_samples != '0) begin
                r_count   <= count_inc;
                r_esum    <= '0;
                r_samples <= '0;
                if (conv || count_inc >= r_limit) begin
                    r_finished <= 1'b1;
                end
            end
        end
    end

    // Working registers, multiplier and status
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= t_op'(i_opcode);
            r_x    <= i_x_value;
            r_y    <= i_y_reference;
            r_pred <= '0;
            r_err  <= '0;
            if ((t_op'(i_opcode) == OP_TRAIN || t_op'(i_opcode) == OP_EPOCH) && r_finished) begin
                r_status <= STS_IGNORED;
            end else begin
                r_status <= STS_OK;
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.pred) begin
            r_pred <= pred_now;
        end
        if (i_cmd.err) begin
            r_err <= err_now;
        end
        if (i_cmd.grad) begin
            r_g <= g_now;
        end
        if (i_cmd.epoch && !r_finished) begin
            if (r_samples == '0) begin
                r_status <= STS_EMPTY;
            end else if (conv) begin
                r_status <= STS_CONVERGED;
            end else if (count_inc >= r_limit) begin
                r_status <= STS_LIMIT;
            end else begin
                r_status <= STS_OK;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_out) begin
            o_prediction   <= r_pred;
            o_sample_error <= r_err;
            o_weight_now   <= r_w;
            o_bias_now     <= r_b;
            o_status       <= r_status;
            o_epochs_done  <= r_count;
        end
    end

endmodule

// ===== sv/lrsgd_checker.sv =====
// Port-level checks for the trainer, bound to the top level.
module lrsgd_checker
    import lrsgd_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [DATA_W-1:0] o_prediction,
    input logic signed [DATA_W-1:0] o_sample_error,
    input logic signed [DATA_W-1:0] o_weight_now,
    input logic signed [DATA_W-1:0] o_bias_now,
    input logic [STATUS_W-1:0]      o_status,
    input logic [COUNT_W-1:0]       o_epochs_done
);

    // Reset leaves the block empty and ready
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

    // One word at a time: busy right after an acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while busy");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_prediction)
            && $stable(o_sample_error) && $stable(o_weight_now) && $stable(o_bias_now)
            && $stable(o_status) && $stable(o_epochs_done))
        else $error("stalled result changed");

    // Status codes stay within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= STS_IGNORED)
        else $error("undefined status");

    // Epoch count never goes back between results
    a_epochs_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && $past(o_out_valid) && $past(i_rst_n)
            |-> o_epochs_done >= $past(o_epochs_done))
        else $error("epoch count decreased");

endmodule

bind linear_regression_sgd_trainer_unit lrsgd_checker u_lrsgd_checker (.*);

// ===== test/lrsgd_trainer_checker.sv =====
// Checker for the SGD trainer: mirrors the training state, predicts each result word, compares.
module lrsgd_trainer_checker
    import lrsgd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [DATA_W-1:0] i_x_value,
    input  logic signed [DATA_W-1:0] i_y_reference,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [DATA_W-1:0] i_prediction,
    input  logic signed [DATA_W-1:0] i_sample_error,
    input  logic signed [DATA_W-1:0] i_weight_now,
    input  logic signed [DATA_W-1:0] i_bias_now,
    input  logic [STATUS_W-1:0]      i_status,
    input  logic [COUNT_W-1:0]       i_epochs_done,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned ERR_SUM_MAX = (64'd1 << SUM_W) - 64'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] prediction;
        logic signed [DATA_W-1:0] sample_error;
        logic signed [DATA_W-1:0] weight_now;
        logic signed [DATA_W-1:0] bias_now;
        t_status                  status;
        logic [COUNT_W-1:0]       epochs_done;
    } t_sgd_outcome;

    // Register copies
    logic [RATE_W-1:0]     rate_q;
    logic [CFG_DATA_W-1:0] init_w_q;
    logic [CFG_DATA_W-1:0] init_b_q;
    logic [LIMIT_W-1:0]    limit_q;
    logic [CFG_DATA_W-1:0] thresh_q;

    // Training state
    longint            weight_q;
    longint            bias_q;
    logic [SUM_W-1:0]  err_total;
    logic [COUNT_W-1:0] sample_cnt;
    logic [COUNT_W-1:0] epoch_cnt;
    bit                done_q;
    bit                awaiting_start;

    t_sgd_outcome outcomes_due[$];
    int           failures    = 0;
    int           words_seen  = 0;

    function automatic longint clamp_word(longint v);
        if (v > longint'(DATA_MAX)) return longint'(DATA_MAX);
        if (v < longint'(DATA_MIN)) return longint'(DATA_MIN);
        return v;
    endfunction

    // Exact product, floor shift, clamp to the data range
    function automatic longint scaled_product(longint a, longint b, int sh);
        return clamp_word((a * b) >>> sh);
    endfunction

    function automatic void clear_model();
        rate_q         = 16'd656;
        init_w_q       = 32'd32768;
        init_b_q       = 32'd32768;
        limit_q        = 16'd1000;
        thresh_q       = 32'd1;
        weight_q       = 0;
        bias_q         = 0;
        err_total      = '0;
        sample_cnt     = '0;
        epoch_cnt      = '0;
        done_q         = 1'b0;
        awaiting_start = 1'b1;
    endfunction

    function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (t_cfg_idx'(idx))
            CFG_RATE:   rate_q   = data[RATE_W-1:0];
            CFG_INIT_W: init_w_q = data;
            CFG_INIT_B: init_b_q = data;
            CFG_LIMIT:  limit_q  = data[LIMIT_W-1:0];
            CFG_THRESH: thresh_q = data;
            default: ;
        endcase
    endfunction

    // Advance the trainer by one input word and return the word it reports
    function automatic t_sgd_outcome train_step(t_op op, logic signed [DATA_W-1:0] x,
                                                logic signed [DATA_W-1:0] y);
        t_sgd_outcome r;
        longint       pred;
        longint       err;
        longint       step;
        longint       mag;
        bit           conv;
        pred     = 0;
        err      = 0;
        r.status = STS_OK;
        case (op)
            OP_EPOCH: begin
                if (done_q) begin
                    r.status = STS_IGNORED;
                end else if (sample_cnt == '0) begin
                    r.status = STS_EMPTY;
                end else begin
                    // Average check without a divide
                    conv = 64'(err_total) < 64'(thresh_q) * 64'(sample_cnt);
                    if (epoch_cnt != '1) epoch_cnt++;
                    err_total  = '0;
                    sample_cnt = '0;
                    if (conv) begin
                        r.status = STS_CONVERGED;
                        done_q   = 1'b1;
                    end else if (epoch_cnt >= limit_q) begin
                        r.status = STS_LIMIT;
                        done_q   = 1'b1;
                    end
                end
            end
            OP_TRAIN: begin
                // Load start values on the first training word
                if (awaiting_start && !done_q) begin
                    weight_q       = longint'($signed(init_w_q));
                    bias_q         = longint'($signed(init_b_q));
                    awaiting_start = 1'b0;
                end
                pred = clamp_word(scaled_product(weight_q, x, FRAC_BITS) + bias_q);
                if (done_q) begin
                    r.status = STS_IGNORED;
                end else begin
                    err = clamp_word(longint'(y) - pred);
                    if (sample_cnt != '1) sample_cnt++;
                    if (x == '0) begin
                        bias_q = longint'(y);
                    end else begin
                        step     = scaled_product(err, longint'(rate_q), RATE_W);
                        bias_q   = clamp_word(bias_q + step);
                        weight_q = clamp_word(weight_q + scaled_product(step, x, FRAC_BITS));
                        mag      = (err < 0) ? -err : err;
                        if (64'(mag) > ERR_SUM_MAX - 64'(err_total)) err_total = '1;
                        else err_total = err_total + SUM_W'(mag);
                    end
                end
            end
            default: pred = clamp_word(scaled_product(weight_q, x, FRAC_BITS) + bias_q);
        endcase
        r.prediction   = DATA_W'(pred);
        r.sample_error = DATA_W'(err);
        r.weight_now   = DATA_W'(weight_q);
        r.bias_now     = DATA_W'(bias_q);
        r.epochs_done  = epoch_cnt;
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        failures++;
        $display("%0t: result word %0d: %s is %0h, expected %0h",
                 $time, words_seen, what, got, want);
    endtask

    // Watch all three channels; results are checked before new words are queued
    always @(posedge i_clk) begin : watch
        t_sgd_outcome want;
        t_sgd_outcome got;
        if (!i_rst_n) begin
            clear_model();
            outcomes_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) store_reg(i_cfg_index, i_cfg_data);
            if (i_out_valid && i_out_ready) begin
                got.prediction   = i_prediction;
                got.sample_error = i_sample_error;
                got.weight_now   = i_weight_now;
                got.bias_now     = i_bias_now;
                got.status       = t_status'(i_status);
                got.epochs_done  = i_epochs_done;
                if (outcomes_due.size() == 0) begin
                    flag_mismatch("unexpected word, status", got.status, 0);
                end else begin
                    want = outcomes_due.pop_front();
                    if (got.prediction != want.prediction)
                        flag_mismatch("prediction", got.prediction, want.prediction);
                    if (got.sample_error != want.sample_error)
                        flag_mismatch("sample_error", got.sample_error, want.sample_error);
                    if (got.weight_now != want.weight_now)
                        flag_mismatch("weight_now", got.weight_now, want.weight_now);
                    if (got.bias_now != want.bias_now)
                        flag_mismatch("bias_now", got.bias_now, want.bias_now);
                    if (got.status != want.status)
                        flag_mismatch("status", got.status, want.status);
                    if (got.epochs_done != want.epochs_done)
                        flag_mismatch("epochs_done", got.epochs_done, want.epochs_done);
                end
                words_seen++;
            end
            if (i_in_valid && i_in_ready)
                outcomes_due.push_back(train_step(t_op'(i_opcode), i_x_value, i_y_reference));
        end
        o_pending    <= outcomes_due.size();
        o_fail_count <= failures;
    end

endmodule

// ===== test/linear_regression_sgd_trainer_unit_tb.sv =====
// Testbench top for the SGD trainer: stimulus, output back-pressure and the final verdict.
module linear_regression_sgd_trainer_unit_tb import lrsgd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                   CYCLE_LIMIT   = 400_000;
    localparam int                   RANDOM_WORDS  = 1500;
    localparam int                   RETUNE_EVERY  = 250;
    localparam logic [CFG_IDX_W-1:0] SPARE_CFG_IDX = 3'd7;

    typedef enum int {RX_OPEN, RX_COIN, RX_BUSY, RX_STARVED} t_rx_mode;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [OP_W-1:0]          i_opcode;
    logic signed [DATA_W-1:0] i_x_value;
    logic signed [DATA_W-1:0] i_y_reference;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [DATA_W-1:0] o_prediction;
    logic signed [DATA_W-1:0] o_sample_error;
    logic signed [DATA_W-1:0] o_weight_now;
    logic signed [DATA_W-1:0] o_bias_now;
    logic [STATUS_W-1:0]      o_status;
    logic [COUNT_W-1:0]       o_epochs_done;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;

    int       fail_count;
    int       pending_words;
    int       words_sent = 0;
    int       burst_left = 0;
    t_rx_mode rx_mode    = RX_OPEN;
    int       rx_left    = 0;

    linear_regression_sgd_trainer_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_x_value      (i_x_value),
        .i_y_reference  (i_y_reference),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_prediction   (o_prediction),
        .o_sample_error (o_sample_error),
        .o_weight_now   (o_weight_now),
        .o_bias_now     (o_bias_now),
        .o_status       (o_status),
        .o_epochs_done  (o_epochs_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    lrsgd_trainer_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_x_value      (i_x_value),
        .i_y_reference  (i_y_reference),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_prediction   (o_prediction),
        .i_sample_error (o_sample_error),
        .i_weight_now   (o_weight_now),
        .i_bias_now     (o_bias_now),
        .i_status       (o_status),
        .i_epochs_done  (o_epochs_done),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop if the run hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[linear_regression_sgd_trainer_unit] ERROR");
        $finish;
    end

    // Stall the result side in stretches of different patterns
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:    i_out_ready <= 1'b1;
            RX_COIN:    i_out_ready <= 1'($urandom_range(0, 1));
            RX_BUSY:    i_out_ready <= ($urandom_range(0, 7) != 0);
            RX_STARVED: i_out_ready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    // Present one word and hold it until taken; drop valid only for a gap
    task automatic send_word(input t_op op, input logic [DATA_W-1:0] x,
                             input logic [DATA_W-1:0] y);
        int gap;
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_x_value     <= x;
        i_y_reference <= y;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // Hold off the sender until every result word has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                             input bit last_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (last_word) i_cfg_valid <= 1'b0;
    endtask

    // Samples along a random line with small noise, then close the epoch
    task automatic tidy_epoch();
        int                       n;
        logic signed [DATA_W-1:0] slope;
        logic signed [DATA_W-1:0] icpt;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        longint                   fit;
        slope = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        icpt  = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        n     = $urandom_range(1, 24);
        repeat (n) begin
            if ($urandom_range(0, 15) == 0) x = '0;
            else x = int'($urandom_range(0, 1 << 18)) - (1 << 17);
            fit = (longint'(slope) * longint'(x)) >>> FRAC_BITS;
            y   = DATA_W'(fit + longint'(icpt) + longint'(int'($urandom_range(0, 512)) - 256));
            send_word(OP_TRAIN, x, y);
            if ($urandom_range(0, 5) == 0) send_word(OP_PREDICT, $urandom, $urandom);
        end
        send_word(OP_EPOCH, $urandom, $urandom);
    endtask

    // Arbitrary words of any opcode and full-range values
    task automatic noisy_epoch();
        int n;
        n = $urandom_range(0, 10);
        repeat (n) send_word(t_op'($urandom_range(0, 3)), $urandom, $urandom);
        send_word(OP_EPOCH, $urandom, $urandom);
    endtask

    initial begin
        int next_retune;
        int stop_at;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_opcode      <= OP_TRAIN;
        i_x_value     <= '0;
        i_y_reference <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_RATE;
        i_cfg_data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Before training starts: zero model, both predict codes, empty epoch
        send_word(OP_PREDICT, DATA_MAX, '0);
        send_word(OP_ALT_PRED, DATA_MIN, DATA_MAX);
        send_word(OP_EPOCH, '0, '0);

        // Extreme settings; threshold zero keeps training alive
        settle();
        write_reg(CFG_RATE, 32'h0000_FFFF, 1'b0);
        write_reg(CFG_INIT_W, DATA_MAX, 1'b0);
        write_reg(CFG_INIT_B, DATA_MIN, 1'b0);
        write_reg(CFG_LIMIT, 32'hFFFF_FFFF, 1'b0);
        write_reg(CFG_THRESH, 32'h0000_0000, 1'b1);

        // Start values load, saturation both ways, zero x, back-to-back epochs
        send_word(OP_TRAIN, DATA_MAX, DATA_MIN);
        send_word(OP_TRAIN, DATA_MIN, DATA_MAX);
        send_word(OP_TRAIN, '0, 32'h0001_8000);
        send_word(OP_PREDICT, 32'h0001_0000, '0);
        send_word(OP_PREDICT, 32'hFFFF_FFFF, '0);
        send_word(OP_EPOCH, '0, '0);
        send_word(OP_EPOCH, '0, '0);
        send_word(OP_TRAIN, 32'hFFFF_0000, 32'h0001_0000);
        send_word(OP_TRAIN, '0, DATA_MIN);
        send_word(OP_TRAIN, 32'h0000_0001, 32'hFFFF_FFFF);
        send_word(OP_ALT_PRED, 32'h0002_0000, '0);
        send_word(OP_EPOCH, '0, '0);

        // Zero step size: parameters must not move except by zero x
        settle();
        write_reg(CFG_RATE, 32'h0000_0000, 1'b1);
        send_word(OP_TRAIN, 32'h0001_0000, 32'h0003_0000);
        send_word(OP_TRAIN, 32'hFFFE_0000, 32'h0001_0000);
        send_word(OP_PREDICT, 32'h0001_0000, '0);
        send_word(OP_EPOCH, '0, '0);

        // Smallest step; start values are written again but no longer load
        settle();
        write_reg(CFG_RATE, 32'h0000_0001, 1'b0);
        write_reg(CFG_INIT_W, $urandom, 1'b0);
        write_reg(CFG_INIT_B, $urandom, 1'b0);
        write_reg(SPARE_CFG_IDX, $urandom, 1'b1);
        send_word(OP_TRAIN, 32'h0000_8000, 32'h0000_4000);
        send_word(OP_TRAIN, 32'hFFFF_8000, 32'h0000_2000);
        send_word(OP_EPOCH, '0, '0);

        // Random epochs, mostly well formed, step size retuned now and then
        next_retune = words_sent;
        stop_at     = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            if (words_sent >= next_retune) begin
                settle();
                write_reg(CFG_RATE, {16'($urandom), 16'($urandom_range(32, 2048))}, 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    write_reg(CFG_INIT_W, $urandom, 1'b0);
                    write_reg(CFG_INIT_B, $urandom, 1'b0);
                end
                write_reg(CFG_LIMIT, {16'($urandom), 16'hFFFF}, 1'b1);
                next_retune += RETUNE_EVERY;
            end
            if ($urandom_range(0, 4) == 0) noisy_epoch();
            else tidy_epoch();
            if ($urandom_range(0, 39) == 0) settle();
        end

        // End training by convergence or by the epoch limit, then feed ignored words
        settle();
        if ($urandom_range(0, 1) == 1) begin
            write_reg(CFG_THRESH, 32'hFFFF_FFFF, 1'b1);
        end else begin
            write_reg(CFG_THRESH, 32'h0000_0001, 1'b0);
            if ($urandom_range(0, 1) == 1) write_reg(CFG_LIMIT, {16'($urandom), 16'h0000}, 1'b1);
            else write_reg(CFG_LIMIT, {16'($urandom), 16'($urandom_range(1, 4))}, 1'b1);
        end
        repeat (3) tidy_epoch();
        noisy_epoch();
        tidy_epoch();

        // Drain and give late words a chance to show up
        settle();
        repeat (24) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0)
            $display("[linear_regression_sgd_trainer_unit] OK");
        else
            $display("[linear_regression_sgd_trainer_unit] ERROR");
        $finish;
    end

endmodule
